// ===== design/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg
// Shared widths, register codes, transaction types and the saturation helper
// for the mandelbrot escape-time pixel unit.
// ----------------------------------------------------------------------------
package mep_pkg;

    localparam int WORD_W        = 32;
    localparam int FRACTION_BITS = 28;
    localparam int WIDE_W        = 2 * WORD_W + 2;
    localparam int PIX_W         = 10;
    localparam int STEP_W        = 31;
    localparam int ITER_W        = 16;
    localparam int COLOR_W       = 8;
    localparam int ADDR_W        = 5;
    localparam int DATA_W        = 32;
    localparam int REG_IDX_W     = 3;

    localparam logic [REG_IDX_W-1:0] REG_X_ORIGIN = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_X_STEP   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MAX_ITER = 3'd4;

    localparam logic signed [WORD_W-1:0] X_ORIGIN_RST = -32'sd536870912;
    localparam logic signed [WORD_W-1:0] Y_ORIGIN_RST = -32'sd402653184;
    localparam logic [STEP_W-1:0]        X_STEP_RST   = 31'd786432;
    localparam logic [STEP_W-1:0]        Y_STEP_RST   = 31'd786432;
    localparam logic [ITER_W-1:0]        MAX_ITER_RST = 16'd512;

    localparam logic signed [WIDE_W-1:0] WIDE_MAX =
        (WIDE_W'(1) << (WORD_W - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] WIDE_MIN = -WIDE_MAX - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] FOUR_Q   = WIDE_W'(4) << FRACTION_BITS;

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
    } pixel_in_t;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [ITER_W-1:0]  iteration_count;
        logic               inside_set;
    } pixel_out_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] x_origin;
        logic signed [WORD_W-1:0] y_origin;
        logic [STEP_W-1:0]        x_step;
        logic [STEP_W-1:0]        y_step;
        logic [ITER_W-1:0]        iter_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] zr2;
        logic signed [WORD_W-1:0] zi2;
        logic signed [WORD_W-1:0] twice;
    } sq_t;

    function automatic logic signed [WORD_W-1:0] sat_word(
        input logic signed [WIDE_W-1:0] v
    );
        logic signed [WORD_W-1:0] r;
        if (v > WIDE_MAX)
            r = WORD_MAX;
        else if (v < WIDE_MIN)
            r = WORD_MIN;
        else
            r = WORD_W'(v);
        return r;
    endfunction

endpackage

// ===== design/mep_cfg.sv =====
// ----------------------------------------------------------------------------
// mep_cfg
// APB register file holding the view window and the iteration limit.
// ----------------------------------------------------------------------------
module mep_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mep_pkg::ADDR_W-1:0]  paddr,
    input  logic [mep_pkg::DATA_W-1:0]  pwdata,
    output logic [mep_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output mep_pkg::cfg_t               cfg
);
    import mep_pkg::*;

    cfg_t                   cfg_reg;
    cfg_t                   cfg_next;
    logic [REG_IDX_W-1:0]   idx;
    logic                   wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_X_ORIGIN: cfg_next.x_origin   = $signed(pwdata[WORD_W-1:0]);
                REG_Y_ORIGIN: cfg_next.y_origin   = $signed(pwdata[WORD_W-1:0]);
                REG_X_STEP:   cfg_next.x_step     = pwdata[STEP_W-1:0];
                REG_Y_STEP:   cfg_next.y_step     = pwdata[STEP_W-1:0];
                REG_MAX_ITER: cfg_next.iter_limit = pwdata[ITER_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_X_ORIGIN: prdata = DATA_W'(unsigned'(cfg_reg.x_origin));
            REG_Y_ORIGIN: prdata = DATA_W'(unsigned'(cfg_reg.y_origin));
            REG_X_STEP:   prdata = DATA_W'(cfg_reg.x_step);
            REG_Y_STEP:   prdata = DATA_W'(cfg_reg.y_step);
            REG_MAX_ITER: prdata = DATA_W'(cfg_reg.iter_limit);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_origin   <= X_ORIGIN_RST;
            cfg_reg.y_origin   <= Y_ORIGIN_RST;
            cfg_reg.x_step     <= X_STEP_RST;
            cfg_reg.y_step     <= Y_STEP_RST;
            cfg_reg.iter_limit <= MAX_ITER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/mep_sqr.sv =====
// ----------------------------------------------------------------------------
// mep_sqr
// Shared complex-square unit: registered products of z, then floor shift and
// saturation to the fixed-point word.
// ----------------------------------------------------------------------------
module mep_sqr (
    input  logic                               clk,
    input  logic signed [mep_pkg::WORD_W-1:0]  zr,
    input  logic signed [mep_pkg::WORD_W-1:0]  zi,
    output mep_pkg::sq_t                       sq
);
    import mep_pkg::*;

    logic signed [2*WORD_W-1:0] rr_reg;
    logic signed [2*WORD_W-1:0] ii_reg;
    logic signed [2*WORD_W-1:0] ri_reg;
    logic signed [2*WORD_W-1:0] rr_next;
    logic signed [2*WORD_W-1:0] ii_next;
    logic signed [2*WORD_W-1:0] ri_next;

    assign rr_next = zr * zr;
    assign ii_next = zi * zi;
    assign ri_next = zr * zi;

    always_ff @(posedge clk)
    begin
        rr_reg <= rr_next;
        ii_reg <= ii_next;
        ri_reg <= ri_next;
    end

    assign sq.zr2   = sat_word(WIDE_W'(rr_reg >>> FRACTION_BITS));
    assign sq.zi2   = sat_word(WIDE_W'(ii_reg >>> FRACTION_BITS));
    assign sq.twice = sat_word(WIDE_W'(ri_reg >>> (FRACTION_BITS - 1)));

endmodule

// ===== design/mep_color.sv =====
// ----------------------------------------------------------------------------
// mep_color
// Maps an iteration count to the pixel color, black when inside the set.
// ----------------------------------------------------------------------------
module mep_color (
    input  logic [mep_pkg::ITER_W-1:0]  count,
    input  logic                        in_set,
    output mep_pkg::pixel_out_t         pix
);
    import mep_pkg::*;

    localparam int SCALED_W = ITER_W + 4;

    logic [SCALED_W-1:0] n_ext;
    logic [SCALED_W-1:0] x3;
    logic [SCALED_W-1:0] x6;
    logic [SCALED_W-1:0] x12;

    function automatic logic [COLOR_W-1:0] mod255(input logic [SCALED_W-1:0] v);
        logic [9:0] s1;
        logic [8:0] s2;
        logic [COLOR_W-1:0] r;
        s1 = 10'(v[7:0]) + 10'(v[15:8]) + 10'(v[SCALED_W-1:16]);
        s2 = 9'(s1[7:0]) + 9'(s1[9:8]);
        if (s2 >= 9'd255)
            r = COLOR_W'(s2 - 9'd255);
        else
            r = COLOR_W'(s2);
        return r;
    endfunction

    assign n_ext = SCALED_W'(count);
    assign x3    = (n_ext << 1) + n_ext;
    assign x6    = x3 << 1;
    assign x12   = x3 << 2;

    always_comb
    begin
        pix.iteration_count = count;
        pix.inside_set      = in_set;
        if (in_set)
        begin
            pix.red   = '0;
            pix.green = '0;
            pix.blue  = '0;
        end
        else
        begin
            pix.red   = mod255(x6);
            pix.green = mod255(x3);
            pix.blue  = mod255(x12);
        end
    end

endmodule

// ===== design/mep_core.sv =====
// ----------------------------------------------------------------------------
// mep_core
// Sequencer around the shared square unit: maps the pixel to c, iterates
// z = z*z + c until escape or limit, then issues one colored result.
// ----------------------------------------------------------------------------
module mep_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mep_pkg::cfg_t         cfg,
    input  logic                  start,
    input  mep_pkg::pixel_in_t    pixel,
    output logic                  busy,
    output logic                  done,
    output mep_pkg::pixel_out_t   color
);
    import mep_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAP  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]               state_reg, state_next;
    logic                     done_reg, done_next;
    logic [PIX_W-1:0]         px_reg, px_next;
    logic [PIX_W-1:0]         py_reg, py_next;
    logic signed [WORD_W-1:0] cr_reg, cr_next;
    logic signed [WORD_W-1:0] ci_reg, ci_next;
    logic signed [WORD_W-1:0] zr_reg, zr_next;
    logic signed [WORD_W-1:0] zi_reg, zi_next;
    logic [ITER_W-1:0]        n_reg, n_next;
    pixel_out_t               result_reg, result_next;

    logic [PIX_W+STEP_W-1:0]  xprod;
    logic [PIX_W+STEP_W-1:0]  yprod;
    logic signed [WORD_W-1:0] cr_map;
    logic signed [WORD_W-1:0] ci_map;
    sq_t                      sq;
    logic signed [WORD_W-1:0] norm;
    logic signed [WORD_W-1:0] diff;
    logic signed [WORD_W-1:0] zr_new;
    logic signed [WORD_W-1:0] zi_new;
    logic                     stop;
    logic                     in_set;
    pixel_out_t               color_w;

    mep_sqr u_sqr (
        .clk (clk),
        .zr  (zr_reg),
        .zi  (zi_reg),
        .sq  (sq)
    );

    mep_color u_color (
        .count  (n_reg),
        .in_set (in_set),
        .pix    (color_w)
    );

    assign xprod  = (PIX_W+STEP_W)'(px_reg) * (PIX_W+STEP_W)'(cfg.x_step);
    assign yprod  = (PIX_W+STEP_W)'(py_reg) * (PIX_W+STEP_W)'(cfg.y_step);
    assign cr_map = sat_word(WIDE_W'($signed(cfg.x_origin)) + $signed(WIDE_W'(xprod)));
    assign ci_map = sat_word(WIDE_W'($signed(cfg.y_origin)) + $signed(WIDE_W'(yprod)));

    assign norm   = sat_word(WIDE_W'($signed(sq.zr2)) + WIDE_W'($signed(sq.zi2)));
    assign diff   = sat_word(WIDE_W'($signed(sq.zr2)) - WIDE_W'($signed(sq.zi2)));
    assign zr_new = sat_word(WIDE_W'(diff) + WIDE_W'(cr_reg));
    assign zi_new = sat_word(WIDE_W'($signed(sq.twice)) + WIDE_W'(ci_reg));
    assign stop   = (WIDE_W'(norm) >= FOUR_Q) || (n_reg >= cfg.iter_limit);
    assign in_set = (n_reg == cfg.iter_limit);

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign color = result_reg;

    always_comb
    begin
        state_next  = state_reg;
        done_next   = 1'b0;
        px_next     = px_reg;
        py_next     = py_reg;
        cr_next     = cr_reg;
        ci_next     = ci_reg;
        zr_next     = zr_reg;
        zi_next     = zi_reg;
        n_next      = n_reg;
        result_next = result_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    px_next    = pixel.pixel_x;
                    py_next    = pixel.pixel_y;
                    state_next = S_MAP;
                end
            end
            S_MAP:
            begin
                cr_next    = cr_map;
                ci_next    = ci_map;
                zr_next    = '0;
                zi_next    = '0;
                n_next     = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (stop)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    zr_next    = zr_new;
                    zi_next    = zi_new;
                    n_next     = n_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_OUT:
            begin
                result_next = color_w;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg     <= px_next;
        py_reg     <= py_next;
        cr_reg     <= cr_next;
        ci_reg     <= ci_next;
        zr_reg     <= zr_next;
        zi_reg     <= zi_next;
        n_reg      <= n_next;
        result_reg <= result_next;
    end

endmodule

// ===== design/mandelbrot_escape_pixel_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top
// A transaction is taken when start is high and busy is low. The pixel is
// latched on acceptance; the core then maps it to c in S_MAP, runs S_MUL (a
// multiply in the shared square unit) and S_UPD (the update, including the
// escape or limit check) for each iteration, and colors the result in S_OUT.
// The default iteration limit is 512. done is high for one cycle only and
// the receiver cannot hold it; color keeps the result until the next pixel
// is colored. busy is low again in that same cycle in which done is high.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  mep_pkg::pixel_in_t          pixel,
    output logic                        busy,
    output logic                        done,
    output mep_pkg::pixel_out_t         color,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mep_pkg::ADDR_W-1:0]  paddr,
    input  logic [mep_pkg::DATA_W-1:0]  pwdata,
    output logic [mep_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import mep_pkg::*;

    cfg_t cfg;

    mep_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mep_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .start (start),
        .pixel (pixel),
        .busy  (busy),
        .done  (done),
        .color (color)
    );

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_inside_black: assert property (@(posedge clk) disable iff (!rst_n)
        (done && color.inside_set) |->
            (color.red == '0 && color.green == '0 && color.blue == '0))
        else $error("inside pixel not black");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((color.iteration_count <= cfg.iter_limit) &&
                  (color.inside_set == (color.iteration_count == cfg.iter_limit))))
        else $error("iteration count inconsistent with limit");
`endif

endmodule
